// ===== sv/text_console_writer_top_assert.svh =====
// Assertion macros for the checker file of the console writer.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Property checked at every edge outside reset.
`define TCW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int CELL_COUNT   = ROWS * COLUMNS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int ADDR_W   = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ACTION_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CELL_W-1:0]   cell_t;

  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_CLEAR = 2'd1;
  localparam action_t ACT_READ  = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  function automatic cell_t blank_cell(input logic [ATTR_W-1:0] attr);
    blank_cell = {attr, CH_SPACE};
  endfunction

endpackage

// ===== sv/text_console_writer_top.sv =====
// Channel       | Ports                                           | Handshake
// --------------+-------------------------------------------------+--------------------------
// command in    | in_action, in_char_code, in_cell_index          | start high, busy low
// result out    | out_cursor_row, out_cursor_column, out_cell_word| out_valid for one cycle
// configuration | cfg_text_attribute                              | cfg_write_en high
//
// A printable character or cursor control that does not scroll is answered in
// the next cycle and busy stays low, so such commands may follow every cycle.
// A read passes through the registered read port of the screen memory and the
// READ state before its result is registered. A clear or a scroll walks the
// screen one cell a cycle through the single write port of the screen memory.
// After reset the block runs a clearing pass over all 2000 cells with busy high.
// The receiver cannot stall: each result is valid for exactly one cycle.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [ADDR_W-1:0]   in_cell_index,
  output logic                out_valid,
  output logic [ROW_W-1:0]    out_cursor_row,
  output logic [COL_W-1:0]    out_cursor_column,
  output logic [CELL_W-1:0]   out_cell_word,
  input  logic                cfg_write_en,
  input  logic [ATTR_W-1:0]   cfg_text_attribute
);

  // Sequencer states.
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(SCROLL_CELLS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic              read_oor_r, read_oor_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [CELL_W-1:0] out_word_r, out_word_nxt;

  // The screen memory: one write port and one registered read port.
  cell_t             screen_mem [CELL_COUNT];
  cell_t             rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             mem_wdata;

  logic accept;

  // Put-character evaluation of the cursor, done in the accepting cycle.
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    tab_sum;
  logic [COL_W:0]    put_col_tmp;
  logic              put_row_inc;
  logic [ROW_W-1:0]  put_row_tmp;
  logic [COL_W-1:0]  put_col;
  logic              put_scroll;
  logic              put_print;
  logic [ADDR_W-1:0] put_addr;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    col_ext     = {1'b0, col_r};
    tab_sum     = col_ext + (COL_W+1)'(TAB_STOP);
    put_col_tmp = col_ext;
    put_row_inc = 1'b0;
    put_print   = 1'b0;
    priority if (in_char_code == CH_BACKSPACE) begin
      if (col_r != '0) begin
        put_col_tmp = col_ext - (COL_W+1)'(1);
      end
    end else if (in_char_code == CH_TAB) begin
      // Round up to the next tab stop; the stop is a power of two.
      put_col_tmp = tab_sum & ~((COL_W+1)'(TAB_STOP - 1));
    end else if (in_char_code == CH_CR) begin
      put_col_tmp = '0;
    end else if (in_char_code == CH_LF) begin
      put_col_tmp = '0;
      put_row_inc = 1'b1;
    end else if ((in_char_code[7] == 1'b0) && (in_char_code[6:5] != 2'b00)) begin
      put_print   = 1'b1;
      put_col_tmp = col_ext + (COL_W+1)'(1);
    end else begin
      put_col_tmp = col_ext;
    end
    // Running off the right edge wraps to the start of the next row.
    if (put_col_tmp >= (COL_W+1)'(COLUMNS)) begin
      put_col     = '0;
      put_row_inc = 1'b1;
    end else begin
      put_col     = put_col_tmp[COL_W-1:0];
    end
    put_row_tmp = row_r + ROW_W'(put_row_inc);
    put_scroll  = (put_row_tmp >= ROW_W'(ROWS));
    put_addr    = ADDR_W'(row_r) * ROW_STRIDE + ADDR_W'(col_r);
  end

  // Sequencer: one memory cell per cycle during init, clear, scroll and blank.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    read_oor_nxt  = read_oor_r;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = blank_cell(attr_r);
    mem_raddr     = in_cell_index;

    unique case (state_r)
      ST_INIT: begin
        // Clearing pass after reset always uses the reset attribute.
        mem_we    = 1'b1;
        mem_wdata = blank_cell(RESET_ATTR);
        ptr_nxt   = ptr_r + ADDR_W'(1);
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_PUT: begin
              mem_we    = put_print;
              mem_waddr = put_addr;
              mem_wdata = {attr_r, in_char_code};
              col_nxt   = put_col;
              if (put_scroll) begin
                row_nxt   = ROW_W'(ROWS - 1);
                ptr_nxt   = '0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt       = put_row_tmp;
                out_valid_nxt = 1'b1;
                out_row_nxt   = put_row_tmp;
                out_col_nxt   = put_col;
                out_word_nxt  = '0;
              end
            end
            ACT_CLEAR: begin
              ptr_nxt   = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            ACT_READ: begin
              read_oor_nxt = (in_cell_index > LAST_CELL);
              state_nxt    = ST_READ;
            end
            ACT_NONE: begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = row_r;
              out_col_nxt   = col_r;
              out_word_nxt  = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = row_r;
        out_col_nxt   = col_r;
        out_word_nxt  = read_oor_r ? '0 : rd_data_r;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one row below the pointer, write the data back in the next cycle to the cell one row above it.
        mem_raddr = ptr_r + ROW_STRIDE;
        mem_we    = (ptr_r != '0);
        mem_waddr = ptr_r - ADDR_W'(1);
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_r + ADDR_W'(1);
        if (ptr_r == COPY_END) begin
          ptr_nxt   = COPY_END;
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
        if (ptr_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_word_nxt  = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= screen_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    read_oor_r <= read_oor_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_cell_word     = out_word_r;

endmodule

// ===== sv/tcw_checker.sv =====
`include "text_console_writer_top_assert.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [ACTION_W-1:0] in_action,
  input logic                out_valid,
  input logic [ROW_W-1:0]    out_cursor_row,
  input logic [COL_W-1:0]    out_cursor_column
);

  // The reset clearing pass keeps the block busy and silent.
  `TCW_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |=> (busy && !out_valid))

  // Every reported cursor lies on the screen.
  `TCW_ASSERT(a_cursor_range, clk, rst_n,
    out_valid |-> ((out_cursor_row < ROW_W'(ROWS)) && (out_cursor_column < COL_W'(COLUMNS))))

  // A clear always walks the screen before it answers.
  `TCW_ASSERT(a_clear_busy, clk, rst_n,
    (start && !busy && (in_action == ACT_CLEAR)) |=> (busy && !out_valid))

  // A put either answers at once or starts a scroll.
  `TCW_ASSERT(a_put_answers, clk, rst_n,
    (start && !busy && (in_action == ACT_PUT)) |=> (out_valid || busy))

  // No transaction appears without a command in progress.
  `TCW_ASSERT(a_no_spurious, clk, rst_n, out_valid |-> ($past(busy) || $past(start)))

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_cursor_row   (out_cursor_row),
  .out_cursor_column(out_cursor_column)
);

// ===== dv/text_console_writer_top_tb.sv =====
// Testbench for the text console writer.
//
// Commands go in through the start/busy handshake, one transaction per
// accepted edge. Every accepted command is handed to a scoreboard that keeps
// its own copy of the screen, the cursor and the attribute register. From that
// copy it predicts the cursor position and cell word that the command must
// produce. Results come back on a one-cycle strobe that cannot be held off.
// Each result is compared field by field with the oldest prediction.
//
// The stimulus opens with a short directed sequence. It touches the corners of
// the cell index, every action, both ends of the printable range, the ignored
// bytes, and each cursor control, including a backspace at column zero. The
// bulk of the run is random traffic shaped like console output: lines of
// text, runs of line feeds that push the cursor to the bottom and scroll, tab
// runs that wrap the column, reads near the cursor and across the whole index
// range, clears, and some pure noise. The attribute register is rewritten
// between phases, only once the block has gone quiet.
module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

  // Commands are counted per phase; the attribute changes between phases.
  localparam int PHASE_COUNT    = 5;
  localparam int PHASE_ITEMS    = 266;
  // A clear or a scroll keeps busy high while it walks the whole screen, as does
  // the clearing pass after reset. The idle limit leaves a wide margin over that.
  localparam int IDLE_LIMIT     = 20000;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    cell_t            word;
  } cursor_report_t;

  typedef enum {
    BURST_TEXT,
    BURST_NEWLINES,
    BURST_TABS,
    BURST_READS,
    BURST_NOISE,
    BURST_CLEAR
  } burst_t;

  // The scoreboard owns the predicted screen and the queue of cursor reports
  // that the block still owes.
  class console_scoreboard;
    cell_t             screen [CELL_COUNT];
    int unsigned       row;
    int unsigned       column;
    logic [ATTR_W-1:0] attribute;
    cursor_report_t    owed_reports [$];
    int unsigned       error_count;

    function new();
      attribute   = RESET_ATTR;
      row         = 0;
      column      = 0;
      error_count = 0;
      blank_cells(0, CELL_COUNT);
    endfunction

    function void blank_cells(int first, int last);
      for (int i = first; i < last; i++) begin
        screen[i] = {attribute, CH_SPACE};
      end
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attribute = value;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function void note_command(action_t action, logic [CHAR_W-1:0] code,
                               logic [ADDR_W-1:0] index);
      cursor_report_t rep;
      rep.word = '0;
      case (action)
        ACT_PUT: begin
          if (code == CH_BACKSPACE) begin
            if (column != 0) column--;
          end else if (code == CH_TAB) begin
            column = column + TAB_STOP;
            column = column - column % TAB_STOP;
          end else if (code == CH_CR) begin
            column = 0;
          end else if (code == CH_LF) begin
            column = 0;
            row++;
          end else if (code >= CH_SPACE && code <= CH_LAST_PRINT) begin
            screen[row * COLUMNS + column] = {attribute, code};
            column++;
          end
          // Wrap and scroll apply after every put, ignored bytes included.
          if (column >= COLUMNS) begin
            column = 0;
            row++;
          end
          if (row >= ROWS) begin
            for (int i = 0; i < SCROLL_CELLS; i++) begin
              screen[i] = screen[i + COLUMNS];
            end
            blank_cells(SCROLL_CELLS, CELL_COUNT);
            row = ROWS - 1;
          end
        end
        ACT_CLEAR: begin
          blank_cells(0, CELL_COUNT);
          row    = 0;
          column = 0;
        end
        ACT_READ: begin
          if (index < CELL_COUNT) rep.word = screen[index];
        end
        default: begin
        end
      endcase
      rep.row    = ROW_W'(row);
      rep.column = COL_W'(column);
      owed_reports.push_back(rep);
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= 100) $display("[%0t] ERROR: %s", $time, what);
    endtask

    task check_result(logic [ROW_W-1:0] row_seen, logic [COL_W-1:0] column_seen,
                      cell_t word_seen);
      cursor_report_t want;
      if (owed_reports.size() == 0) begin
        report($sformatf("result row %0d column %0d word %h with nothing owed",
                         row_seen, column_seen, word_seen));
        return;
      end
      want = owed_reports.pop_front();
      if (row_seen !== want.row)
        report($sformatf("cursor_row %0d, predicted %0d", row_seen, want.row));
      if (column_seen !== want.column)
        report($sformatf("cursor_column %0d, predicted %0d", column_seen, want.column));
      if (word_seen !== want.word)
        report($sformatf("cell_word %h, predicted %h", word_seen, want.word));
    endtask
  endclass

  logic                clk;
  logic                rst_n              = 1'b0;
  logic                start              = 1'b0;
  logic                busy;
  action_t             in_action          = ACT_PUT;
  logic [CHAR_W-1:0]   in_char_code       = '0;
  logic [ADDR_W-1:0]   in_cell_index      = '0;
  logic                out_valid;
  logic [ROW_W-1:0]    out_cursor_row;
  logic [COL_W-1:0]    out_cursor_column;
  logic [CELL_W-1:0]   out_cell_word;
  logic                cfg_write_en       = 1'b0;
  logic [ATTR_W-1:0]   cfg_text_attribute = '0;

  console_scoreboard board;
  int                useful_items = 0;
  int                idle_cycles  = 0;

  text_console_writer_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_column  (out_cursor_column),
    .out_cell_word      (out_cell_word),
    .cfg_write_en       (cfg_write_en),
    .cfg_text_attribute (cfg_text_attribute)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything the scoreboard learns, it learns here at the clock edge.
  // A result accepted at an edge always belongs to a command accepted at an
  // earlier edge, so the result is checked before the new command is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_cursor_row, out_cursor_column, out_cell_word);
      if (start && !busy) board.note_command(in_action, in_char_code, in_cell_index);
      if (cfg_write_en) board.set_attribute(cfg_text_attribute);
    end
  end

  // The watchdog counts edges at which no transaction moves in either
  // direction and gives up once the count reaches the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_writer_top: mismatch");
      $finish;
    end
  end

  // Presents one command and returns at the edge that accepts it. Start is
  // left high so that a following command can go out back to back.
  task automatic send_command(action_t action, logic [CHAR_W-1:0] code,
                              logic [ADDR_W-1:0] index);
    start         <= 1'b1;
    in_action     <= action;
    in_char_code  <= code;
    in_cell_index <= index;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (action != ACT_NONE) useful_items++;
  endtask

  // Drops start for a number of cycles; callers always pass at least one.
  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every owed result has arrived and busy has stayed low for a
  // few edges in a row, so that a scroll started late cannot be missed.
  task automatic wait_for_idle();
    int quiet;
    quiet = 0;
    start <= 1'b0;
    while (quiet < 3) begin
      @(posedge clk);
      if (board.pending() == 0 && !busy) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    cfg_text_attribute <= value;
    cfg_write_en       <= 1'b1;
    @(posedge clk);
    cfg_write_en       <= 1'b0;
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr;
    logic [CHAR_W-1:0] code;
    burst_t            burst;
    int                roll;
    int                burst_count;
    int                phase_goal;

    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the attribute left at its reset value. The
    // first command waits out the clearing pass that follows reset.
    send_command(ACT_READ, 8'($urandom), 11'd0);
    send_command(ACT_READ, 8'($urandom), 11'(CELL_COUNT - 1));
    send_command(ACT_READ, 8'($urandom), 11'(CELL_COUNT));   // first index past the screen
    send_command(ACT_READ, 8'($urandom), 11'h7FF);
    send_command(ACT_NONE, 8'hFF, 11'h7FF);
    send_command(ACT_PUT, CH_SPACE, 11'($urandom));
    send_command(ACT_PUT, CH_LAST_PRINT, 11'($urandom));
    send_command(ACT_PUT, 8'h41, 11'($urandom));
    // Control bytes without a meaning, and bytes with the top bit set, are
    // ignored but still produce a result.
    send_command(ACT_PUT, 8'h1F, 11'($urandom));
    send_command(ACT_PUT, 8'h80, 11'($urandom));
    send_command(ACT_PUT, 8'hFF, 11'($urandom));
    send_command(ACT_PUT, 8'h00, 11'($urandom));
    send_command(ACT_PUT, CH_BACKSPACE, 11'($urandom));
    send_command(ACT_PUT, CH_TAB, 11'($urandom));
    send_command(ACT_PUT, CH_TAB, 11'($urandom));
    send_command(ACT_PUT, CH_CR, 11'($urandom));
    // A backspace at column zero must leave the cursor where it is.
    send_command(ACT_PUT, CH_BACKSPACE, 11'($urandom));
    send_command(ACT_PUT, CH_LF, 11'($urandom));
    send_command(ACT_READ, 8'($urandom), 11'd1);
    send_command(ACT_READ, 8'($urandom), 11'd2);
    send_command(ACT_CLEAR, 8'($urandom), 11'($urandom));
    send_command(ACT_READ, 8'($urandom), 11'd2);

    // Random part. Each phase first lets the block go quiet and then loads a
    // new attribute; the first two phases use the two extreme values.
    burst_count = 0;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_idle();
      if (phase == 0) phase_attr = '0;
      else if (phase == 1) phase_attr = '1;
      else phase_attr = ATTR_W'($urandom);
      write_attribute(phase_attr);
      phase_goal = useful_items + PHASE_ITEMS;

      while (useful_items < phase_goal) begin
        roll = $urandom_range(99);
        if (roll < 35) burst = BURST_TEXT;
        else if (roll < 47) burst = BURST_NEWLINES;
        else if (roll < 57) burst = BURST_TABS;
        else if (roll < 77) burst = BURST_READS;
        else if (roll < 95) burst = BURST_NOISE;
        else burst = BURST_CLEAR;

        case (burst)
          BURST_TEXT: begin
            // A line of text with the odd cursor control mixed in. Long lines
            // wrap, and on the bottom row they scroll.
            repeat ($urandom_range(60, 5)) begin
              roll = $urandom_range(99);
              if (roll < 85) code = CHAR_W'($urandom_range(CH_LAST_PRINT, CH_SPACE));
              else if (roll < 89) code = CH_LF;
              else if (roll < 92) code = CH_CR;
              else if (roll < 95) code = CH_BACKSPACE;
              else code = CH_TAB;
              send_command(ACT_PUT, code, 11'($urandom));
              if ($urandom_range(9) == 0) pause_sender($urandom_range(3, 1));
            end
          end
          BURST_NEWLINES: begin
            // Runs of line feeds that move the cursor down and, on the bottom row, scroll.
            repeat ($urandom_range(20, 1)) send_command(ACT_PUT, CH_LF, 11'($urandom));
          end
          BURST_TABS: begin
            repeat ($urandom_range(12, 1)) begin
              code = ($urandom_range(4) == 0) ? CH_BACKSPACE : CH_TAB;
              send_command(ACT_PUT, code, 11'($urandom));
            end
          end
          BURST_READS: begin
            // Half of the reads land on the cursor row, where the latest text is.
            repeat ($urandom_range(10, 1)) begin
              roll = $urandom_range(99);
              if (roll < 50)
                send_command(ACT_READ, 8'($urandom),
                             11'(board.row * COLUMNS + $urandom_range(COLUMNS - 1)));
              else if (roll < 80)
                send_command(ACT_READ, 8'($urandom), 11'($urandom_range(CELL_COUNT - 1)));
              else
                send_command(ACT_READ, 8'($urandom), 11'($urandom));
            end
          end
          BURST_NOISE: begin
            repeat ($urandom_range(8, 1))
              send_command(action_t'($urandom_range(3)), 8'($urandom), 11'($urandom));
          end
          default: begin
            send_command(ACT_CLEAR, 8'($urandom), 11'($urandom));
          end
        endcase

        // Gaps between bursts vary from none at all to a fair stretch. Every
        // tenth burst the sender holds back until all results are home.
        burst_count++;
        if (burst_count % 10 == 0) begin
          wait_for_idle();
        end else begin
          roll = $urandom_range(99);
          if (roll >= 80) pause_sender($urandom_range(20, 5));
          else if (roll >= 35) pause_sender($urandom_range(4, 1));
        end
      end
    end

    // Let the last results drain, then give a stray strobe a chance to show.
    wait_for_idle();
    repeat (8) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.error_count == 0) begin
      $display("text_console_writer_top: match");
    end else begin
      $display("text_console_writer_top: mismatch");
    end
    $finish;
  end

endmodule
